[rtl/pspm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pspm_pkg
// Shared types and constants for the controller poller.
// ----------------------------------------------------------------------------
package pspm_pkg;
	localparam int unsigned PERIOD_W = 20;
	localparam logic [19:0] PERIOD_RST = 20'd16000;
	localparam logic [7:0] LEAD_RST = 8'd50;
	localparam logic [7:0] PHASE_RST = 8'd2;
	localparam logic [7:0] GAP_RST = 8'd20;
	localparam logic [7:0] ID_RST = 8'h23;
	localparam logic [7:0] CMD_START = 8'h01;
	localparam logic [7:0] CMD_POLL = 8'h42;
	localparam logic [3:0] LAST_BYTE = 4'd9;

	localparam logic [2:0] REG_PERIOD = 3'd0;
	localparam logic [2:0] REG_LEAD = 3'd1;
	localparam logic [2:0] REG_PHASE = 3'd2;
	localparam logic [2:0] REG_GAP = 3'd3;
	localparam logic [2:0] REG_ID = 3'd4;

	// front -> back: one tick's result of the sequencer
	typedef struct packed {
		logic att;
		logic clk;
		logic cmd;
		logic conn;
		logic done;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] twist;
		logic [7:0] an0;
		logic [7:0] an1;
		logic [7:0] an2;
	} tick_t;
endpackage
`default_nettype wire

[rtl/psx_pad_poller_steering_map.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// psx_pad_poller_steering_map
// Controller poller: front sequencer per tick, back output stage with curve.
// Path: an accepted tick is loaded into the slot, passes B_T, B_CURVE and B_AMP, and is offered in B_OUT.
// One tick at a time: slot load, three curve steps, unload; ticks stall until the slot empties.
// Reset: async low; registers to defaults, stored bytes to released/centre.
// ----------------------------------------------------------------------------
module psx_pad_poller_steering_map (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_idx,
	input  wire logic [19:0] cfg_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic data_pin,
	output logic out_valid,
	input  wire logic out_stall,
	output logic attention_pin,
	output logic clock_pin,
	output logic command_pin,
	output logic pad_connected,
	output logic frame_done,
	output logic [3:0] dpad_bits,
	output logic [3:0] button_bits,
	output logic [15:0] steer_axis,
	output logic [15:0] right_trigger,
	output logic [15:0] left_trigger,
	output logic [15:0] right_y_axis
);
	pspm_pkg::tick_t item;
	logic iv, ifull;

	pspm_front u_front (.clk, .arst_n, .cfg_we, .cfg_idx, .cfg_data,
		.tick_valid(in_valid), .tick_stall(in_stall), .data_pin,
		.res_valid(iv), .res_full(ifull), .res(item));

	pspm_back u_back (.clk, .arst_n, .in_valid(iv), .in_full(ifull), .in_item(item),
		.out_valid, .out_stall, .attention_pin, .clock_pin, .command_pin,
		.pad_connected, .frame_done, .dpad_bits, .button_bits, .steer_axis,
		.right_trigger, .left_trigger, .right_y_axis);
endmodule
`default_nettype wire

[rtl/pspm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pspm_front
// Tick sequencer: poll timer, byte framing, bit phases and stored bytes.
// ----------------------------------------------------------------------------
module pspm_front (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [2:0] cfg_idx,
	input  wire logic [19:0] cfg_data,
	input  wire logic tick_valid,
	output logic tick_stall,
	input  wire logic data_pin,
	output logic res_valid,
	input  wire logic res_full,
	output pspm_pkg::tick_t res
);
	typedef enum logic [2:0] {
		S_IDLE = 3'd0, S_LEAD = 3'd1, S_SET = 3'd2, S_LOW = 3'd3, S_HIGH = 3'd4, S_GAP = 3'd5
	} st_t;

	logic [19:0] period_q;
	logic [7:0] lead_q, phase_q, gap_q, id_q;
	logic [19:0] ptmr_q;
	st_t st_q;
	logic [7:0] ptick_q;
	logic [2:0] bit_q;
	logic [3:0] byte_q;
	logic [7:0] tx_q, rx_q, b1_q, b2_q, tw_q, a0_q, a1_q, a2_q;
	logic conn_q;

	assign tick_stall = res_full;
	logic go;
	assign go = tick_valid && !res_full;
	assign res_valid = go;

	logic [7:0] ph;
	assign ph = (phase_q == 8'd0) ? 8'd1 : phase_q;

	// combinational next state of one tick
	st_t s, sn;
	logic [19:0] pt;
	logic [7:0] tm, tmn, tx, rxn;
	logic [2:0] bi, bin;
	logic [3:0] by;
	logic done, ph_end, fin, cmdb;
	logic [7:0] b1n, b2n, twn, a0n, a1n, a2n;
	logic connn;

	always_comb begin
		s = st_q;
		pt = (ptmr_q != 20'hFFFFF) ? ptmr_q + 20'd1 : ptmr_q;
		tm = ptick_q;
		bi = bit_q;
		by = byte_q;
		tx = tx_q;
		done = 1'b0;
		if (s == S_IDLE && pt >= period_q) begin
			pt = '0; s = S_LEAD; tm = '0; by = '0;
		end
		if (s == S_LEAD && tm >= lead_q) begin
			by = '0; tx = pspm_pkg::CMD_START; s = S_SET; tm = '0; bi = '0;
		end else if (s == S_GAP && tm >= gap_q) begin
			if ((by == 4'd1 && rx_q != id_q) || by >= pspm_pkg::LAST_BYTE) begin
				s = S_IDLE; tm = '0; by = '0; done = 1'b1;
			end else begin
				by = by + 4'd1;
				tx = (by == 4'd1) ? pspm_pkg::CMD_POLL : 8'h00;
				s = S_SET; tm = '0; bi = '0;
			end
		end
		cmdb = tx[bi];
		sn = s; tmn = tm; bin = bi; rxn = rx_q; fin = 1'b0;
		ph_end = ({1'b0, tm} + 9'd1) >= {1'b0, ph};
		case (s)
			S_LEAD, S_GAP: if (tm != 8'hFF) tmn = tm + 8'd1;
			S_SET: if (ph_end) begin sn = S_LOW; tmn = '0; end else tmn = tm + 8'd1;
			S_LOW: if (ph_end) begin
				rxn[bi] = data_pin; sn = S_HIGH; tmn = '0;
			end else tmn = tm + 8'd1;
			S_HIGH: if (ph_end) begin
				tmn = '0;
				if (bi == 3'd7) begin fin = 1'b1; sn = S_GAP; end
				else begin bin = bi + 3'd1; sn = S_SET; end
			end else tmn = tm + 8'd1;
			default: ;
		endcase
		b1n = b1_q; b2n = b2_q; twn = tw_q; a0n = a0_q; a1n = a1_q; a2n = a2_q;
		connn = conn_q;
		if (fin) begin
			case (by)
				4'd1: if (rxn == id_q) connn = 1'b1;
				4'd3: b1n = rxn;
				4'd4: b2n = rxn;
				4'd5: twn = rxn;
				4'd6: a0n = rxn;
				4'd7: a1n = rxn;
				4'd8: a2n = rxn;
				default: ;
			endcase
		end
		res.att = (s == S_IDLE);
		res.clk = (s != S_LOW);
		res.cmd = (s == S_SET || s == S_LOW || s == S_HIGH) ? cmdb : 1'b1;
		res.conn = connn;
		res.done = done;
		res.b1 = b1n; res.b2 = b2n; res.twist = twn;
		res.an0 = a0n; res.an1 = a1n; res.an2 = a2n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= pspm_pkg::PERIOD_RST; lead_q <= pspm_pkg::LEAD_RST;
			phase_q <= pspm_pkg::PHASE_RST; gap_q <= pspm_pkg::GAP_RST;
			id_q <= pspm_pkg::ID_RST;
			ptmr_q <= '0; st_q <= S_IDLE; ptick_q <= '0; bit_q <= '0; byte_q <= '0;
			tx_q <= '0; rx_q <= '0; b1_q <= 8'hFF; b2_q <= 8'hFF; tw_q <= 8'd127;
			a0_q <= '0; a1_q <= '0; a2_q <= 8'd128; conn_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					pspm_pkg::REG_PERIOD: period_q <= cfg_data;
					pspm_pkg::REG_LEAD: lead_q <= cfg_data[7:0];
					pspm_pkg::REG_PHASE: phase_q <= cfg_data[7:0];
					pspm_pkg::REG_GAP: gap_q <= cfg_data[7:0];
					pspm_pkg::REG_ID: id_q <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (go) begin
				ptmr_q <= pt; st_q <= sn; ptick_q <= tmn; bit_q <= bin; byte_q <= by;
				tx_q <= tx; rx_q <= rxn; b1_q <= b1n; b2_q <= b2n; tw_q <= twn;
				a0_q <= a0n; a1_q <= a1n; a2_q <= a2n; conn_q <= connn;
			end
		end
	end

`ifndef SYNTHESIS
	a_conn_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		conn_q |=> conn_q) else $error("connected flag cleared");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(go && res.done) |=> (st_q == S_IDLE)) else $error("frame end not idle");
	a_clk_low: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !res.clk) |-> !res.att) else $error("clock low outside frame");
`endif
endmodule
`default_nettype wire

[rtl/pspm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pspm_back
// Queue slot plus output stage: button decode and steering curve over cycles.
// ----------------------------------------------------------------------------
module pspm_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_full,
	input  wire pspm_pkg::tick_t in_item,
	output logic out_valid,
	input  wire logic out_stall,
	output logic attention_pin,
	output logic clock_pin,
	output logic command_pin,
	output logic pad_connected,
	output logic frame_done,
	output logic [3:0] dpad_bits,
	output logic [3:0] button_bits,
	output logic [15:0] steer_axis,
	output logic [15:0] right_trigger,
	output logic [15:0] left_trigger,
	output logic [15:0] right_y_axis
);
	typedef enum logic [2:0] {B_EMPTY, B_T, B_CURVE, B_AMP, B_OUT} bst_t;
	bst_t st_q;
	pspm_pkg::tick_t it_q;
	logic pos_q, zero_q;
	logic [13:0] t_q;
	logic [14:0] curve_q;
	logic [15:0] amp_q;

	assign in_full = (st_q != B_EMPTY);
	assign out_valid = (st_q == B_OUT);

	logic [7:0] mag;
	logic [6:0] nx;
	logic pos;
	always_comb begin
		pos = it_q.twist > 8'd127;
		mag = pos ? it_q.twist - 8'd127 : 8'd127 - it_q.twist;
		nx = (mag - 8'd4 > 8'd123) ? 7'd123 : 7'(mag - 8'd4);
	end
	// nx*10000/123 via reciprocal, then one correction
	logic [27:0] tp;
	logic [20:0] tr;
	logic [13:0] tt;
	always_comb begin
		tp = 28'(nx) * 28'd10000;
		tr = 21'((36'(tp) * 36'd34100) >> 22);
		tt = (21'(tp) - tr * 21'd123 >= 21'd123) ? 14'(tr + 21'd1) : 14'(tr);
	end
	logic [27:0] sq;
	logic [14:0] sqd;
	always_comb begin
		sq = 28'(t_q) * 28'(t_q);
		sqd = 15'((48'(sq) * 48'd1717986) >> 34);
		if (sq - 28'(sqd) * 28'd10000 >= 28'd10000) sqd = sqd + 15'd1;
	end
	logic [28:0] ap;
	logic [15:0] ad;
	always_comb begin
		ap = 29'(curve_q) * 29'd29490;
		ad = 16'((50'(ap) * 50'd1717986) >> 34);
		if (ap - 29'(ad) * 29'd10000 >= 29'd10000) ad = ad + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_EMPTY;
		end else begin
			case (st_q)
				B_EMPTY: if (in_valid) begin it_q <= in_item; st_q <= B_T; end
				B_T: begin
					pos_q <= pos; zero_q <= mag < 8'd4; t_q <= tt; st_q <= B_CURVE;
				end
				B_CURVE: begin curve_q <= 15'({t_q, 1'b0} - 15'(sqd)); st_q <= B_AMP; end
				B_AMP: begin
					amp_q <= 16'd3277 + ad;
					st_q <= B_OUT;
				end
				B_OUT: if (!out_stall) st_q <= B_EMPTY;
				default: st_q <= B_EMPTY;
			endcase
		end
	end

	logic [16:0] pv;
	always_comb begin
		pv = 17'd32768 + 17'(amp_q);
		attention_pin = it_q.att;
		clock_pin = it_q.clk;
		command_pin = it_q.cmd;
		pad_connected = it_q.conn;
		frame_done = it_q.done;
		dpad_bits = ~{it_q.b1[7], it_q.b1[6], it_q.b1[5], it_q.b1[4]};
		button_bits = ~{it_q.b2[3], it_q.b2[5], it_q.b2[4], it_q.b1[3]};
		if (zero_q) steer_axis = 16'd32768;
		else if (pos_q) steer_axis = pv[16] ? 16'hFFFF : pv[15:0];
		else steer_axis = (amp_q > 16'd32768) ? 16'd0 : 16'd32768 - amp_q;
		right_trigger = {it_q.an0, it_q.an0};
		left_trigger = {it_q.an1, it_q.an1};
		right_y_axis = {1'b1, it_q.an2, 7'd0};
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid) else $error("result dropped");
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_T) |=> (st_q == B_CURVE)) else $error("curve order");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == B_EMPTY && in_valid) |=> in_full) else $error("slot not taken");
`endif
endmodule
`default_nettype wire
